/* src/t8c_pkg.sv */
// Shared types and constants for the toy 8-bit core.
package t8c_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
  } t8c_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic [15:0] prog_counter;
    logic [7:0]  result_reg;
    logic        zero_flag;
  } t8c_out_t;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_STEP    = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_BADOP   = 3'd2;
  localparam logic [2:0] ST_SYSCALL = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;
  localparam logic [2:0] ST_BADREG  = 3'd5;

  localparam logic [7:0] OP_ADD     = 8'h00;
  localparam logic [7:0] OP_SUB     = 8'h01;
  localparam logic [7:0] OP_MUL     = 8'h02;
  localparam logic [7:0] OP_DIV     = 8'h03;
  localparam logic [7:0] OP_AND     = 8'h04;
  localparam logic [7:0] OP_OR      = 8'h05;
  localparam logic [7:0] OP_XOR     = 8'h06;
  localparam logic [7:0] OP_NOT     = 8'h07;
  localparam logic [7:0] OP_LOAD    = 8'h08;
  localparam logic [7:0] OP_STORE   = 8'h09;
  localparam logic [7:0] OP_MOVE    = 8'h0A;
  localparam logic [7:0] OP_JMP     = 8'h0B;
  localparam logic [7:0] OP_JMPZ    = 8'h0C;
  localparam logic [7:0] OP_CALL    = 8'h0D;
  localparam logic [7:0] OP_RET     = 8'h0E;
  localparam logic [7:0] OP_HALT    = 8'h0F;
  localparam logic [7:0] OP_SYSCALL = 8'hA0;

  // Memory address select from controller to datapath.
  localparam logic [1:0] AS_PC   = 2'd0;
  localparam logic [1:0] AS_HOST = 2'd1;
  localparam logic [1:0] AS_TGT  = 2'd2;
  localparam logic [1:0] AS_SP   = 2'd3;

  // Byte latch destinations.
  localparam logic [2:0] LD_NONE = 3'd0;
  localparam logic [2:0] LD_OP   = 3'd1;
  localparam logic [2:0] LD_RA   = 3'd2;
  localparam logic [2:0] LD_HI   = 3'd3;
  localparam logic [2:0] LD_LO   = 3'd4;
  localparam logic [2:0] LD_REG  = 3'd5;
  localparam logic [2:0] LD_RD   = 3'd6;

  // Memory write data select.
  localparam logic [1:0] WD_HOST = 2'd0;
  localparam logic [1:0] WD_REG  = 2'd1;
  localparam logic [1:0] WD_PCLO = 2'd2;
  localparam logic [1:0] WD_PCHI = 2'd3;

  // Architectural action at end of an instruction.
  localparam logic [3:0] AC_NONE    = 4'd0;
  localparam logic [3:0] AC_ALU     = 4'd1;
  localparam logic [3:0] AC_MOVE    = 4'd2;
  localparam logic [3:0] AC_JUMP    = 4'd3;
  localparam logic [3:0] AC_JMPZ    = 4'd4;
  localparam logic [3:0] AC_RESTART = 4'd5;
  localparam logic [3:0] AC_FAULT   = 4'd6;
  localparam logic [3:0] AC_PCLOAD  = 4'd7;

  typedef struct packed {
    logic [1:0] addr_sel;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] wdata_sel;
    logic [2:0] latch;
    logic       pc_inc;
    logic       sp_dec;
    logic       sp_inc;
    logic       div_start;
    logic       clr_rd;
    logic [3:0] action;
    logic [2:0] fault_code;
    logic       out_load;
  } t8c_cmd_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       ra_bad;
    logic       rb_bad;
    logic       div_zero;
    logic       div_busy;
    logic       stopped;
  } t8c_stat_t;

endpackage

/* src/t8c_datapath.sv */
// Datapath of the toy 8-bit core: memory, registers, PC, SP, ALU, divider.
module t8c_datapath #(
  parameter int NUM_REGS  = 4,
  parameter int MEM_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  t8c_pkg::t8c_in_t    req,
  input  logic [15:0]         boot_pc,
  input  logic [15:0]         stack_top,
  input  t8c_pkg::t8c_cmd_t   cmd,
  output t8c_pkg::t8c_stat_t  stat,
  output t8c_pkg::t8c_out_t   res
);
  import t8c_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = $clog2(NUM_REGS);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rdata_r;
  logic [7:0]  regs_r [NUM_REGS];
  logic [15:0] pc_r, sp_r;
  logic        zero_r;
  logic [2:0]  stop_r;
  logic [7:0]  op_r, ra_r, hi_r, lo_r, rdout_r;
  logic [7:0]  quot_r, rem_r, dsh_r;
  logic [3:0]  dcnt_r;
  t8c_out_t    res_r;
  logic [15:0] addr;
  logic [15:0] tgt;
  logic [7:0]  wdata;
  logic [7:0]  alu_res;
  logic [8:0]  rem_try;
  logic [RW-1:0] ra_idx, rb_idx;

  assign tgt    = {hi_r, lo_r};
  assign ra_idx = ra_r[RW-1:0];
  assign rb_idx = lo_r[RW-1:0];

  always_comb begin
    case (cmd.addr_sel)
      AS_PC:   addr = pc_r;
      AS_HOST: addr = req.mem_addr;
      AS_TGT:  addr = tgt;
      default: addr = sp_r;
    endcase
    case (cmd.wdata_sel)
      WD_HOST: wdata = req.mem_data;
      WD_REG:  wdata = regs_r[ra_idx];
      WD_PCLO: wdata = pc_r[7:0];
      default: wdata = pc_r[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr[AW-1:0]] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[addr[AW-1:0]];
  end

  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = regs_r[1] + regs_r[2];
      OP_SUB:  alu_res = regs_r[1] - regs_r[2];
      OP_MUL:  alu_res = 8'(regs_r[1] * regs_r[2]);
      OP_DIV:  alu_res = quot_r;
      OP_AND:  alu_res = regs_r[1] & regs_r[2];
      OP_OR:   alu_res = regs_r[1] | regs_r[2];
      OP_XOR:  alu_res = regs_r[1] ^ regs_r[2];
      default: alu_res = ~regs_r[1];
    endcase
  end

  // Restoring divider, one quotient bit a cycle.
  assign rem_try = {rem_r, dsh_r[7]} - {1'b0, regs_r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= 4'd8;
      rem_r  <= '0;
      dsh_r  <= regs_r[1];
      quot_r <= '0;
    end else if (dcnt_r != 4'd0) begin
      dcnt_r <= dcnt_r - 4'd1;
      dsh_r  <= {dsh_r[6:0], 1'b0};
      if (!rem_try[8]) begin
        rem_r  <= rem_try[7:0];
        quot_r <= {quot_r[6:0], 1'b1};
      end else begin
        rem_r  <= {rem_r[6:0], dsh_r[7]};
        quot_r <= {quot_r[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
      pc_r    <= '0;
      sp_r    <= '0;
      zero_r  <= 1'b0;
      stop_r  <= ST_OK;
      rdout_r <= '0;
      op_r    <= '0;
      ra_r    <= '0;
      hi_r    <= '0;
      lo_r    <= '0;
      res_r   <= '0;
    end else begin
      if (cmd.pc_inc) pc_r <= pc_r + 16'd1;
      if (cmd.sp_dec) sp_r <= sp_r - 16'd1;
      if (cmd.sp_inc) sp_r <= sp_r + 16'd1;
      if (cmd.clr_rd) rdout_r <= '0;
      if (cmd.out_load) res_r <= {stop_r, rdout_r, pc_r, regs_r[0], zero_r};
      case (cmd.latch)
        LD_OP:   op_r <= rdata_r;
        LD_RA:   ra_r <= rdata_r;
        LD_HI:   hi_r <= rdata_r;
        LD_LO:   lo_r <= rdata_r;
        LD_REG:  regs_r[ra_idx] <= rdata_r;
        LD_RD:   rdout_r <= rdata_r;
        default: ;
      endcase
      case (cmd.action)
        AC_ALU: begin
          regs_r[0] <= alu_res;
          zero_r    <= (alu_res == 8'd0);
        end
        AC_MOVE:  regs_r[ra_idx] <= regs_r[rb_idx];
        AC_JUMP:  pc_r <= tgt;
        AC_JMPZ:  if (zero_r) pc_r <= tgt;
        AC_PCLOAD: pc_r <= {hi_r, rdata_r};
        AC_RESTART: begin
          pc_r   <= boot_pc;
          sp_r   <= stack_top;
          zero_r <= 1'b0;
          stop_r <= ST_OK;
        end
        AC_FAULT: stop_r <= cmd.fault_code;
        default: ;
      endcase
    end
  end

  assign stat.opcode   = op_r;
  assign stat.ra_bad   = (32'(ra_r) >= NUM_REGS);
  assign stat.rb_bad   = (32'(lo_r) >= NUM_REGS);
  assign stat.div_zero = (regs_r[2] == 8'd0);
  assign stat.div_busy = (dcnt_r != 4'd0);
  assign stat.stopped  = (stop_r != ST_OK);

  assign res = res_r;

endmodule

/* src/t8c_ctrl.sv */
// Controller state machine of the toy 8-bit core.
module t8c_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  input  t8c_pkg::t8c_stat_t stat,
  output t8c_pkg::t8c_cmd_t  cmd
);
  import t8c_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_HRD    = 5'd1;
  localparam logic [4:0] S_OPRD   = 5'd2;
  localparam logic [4:0] S_DEC    = 5'd3;
  localparam logic [4:0] S_B1     = 5'd4;  // first operand byte valid
  localparam logic [4:0] S_B2     = 5'd5;
  localparam logic [4:0] S_B3     = 5'd6;
  localparam logic [4:0] S_MEMRD  = 5'd7;
  localparam logic [4:0] S_MEMLD  = 5'd8;
  localparam logic [4:0] S_DIV    = 5'd9;
  localparam logic [4:0] S_PUSH2  = 5'd10;
  localparam logic [4:0] S_POP1   = 5'd11;
  localparam logic [4:0] S_POP2   = 5'd12;
  localparam logic [4:0] S_DONE   = 5'd13;
  localparam logic [4:0] S_HRDL   = 5'd14;

  logic [4:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       accept;

  // Take a new request whenever the core is idle; a waiting result sits in
  // its own register.
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.clr_rd = 1'b1;
          case (req_cmd)
            CMD_WRITE: begin
              cmd.addr_sel = AS_HOST;
              cmd.mem_wr   = 1'b1;
              cmd.wdata_sel = WD_HOST;
              state_nxt    = S_DONE;
            end
            CMD_READ: begin
              cmd.addr_sel = AS_HOST;
              cmd.mem_rd   = 1'b1;
              state_nxt    = S_HRDL;
            end
            CMD_STEP: begin
              if (stat.stopped) begin
                state_nxt = S_DONE;
              end else begin
                cmd.addr_sel = AS_PC;
                cmd.mem_rd   = 1'b1;
                cmd.pc_inc   = 1'b1;
                state_nxt    = S_OPRD;
              end
            end
            default: begin
              cmd.action = AC_RESTART;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_HRDL: begin
        cmd.latch = LD_RD;
        state_nxt = S_DONE;
      end
      S_OPRD: begin
        cmd.latch = LD_OP;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (stat.opcode <= OP_NOT) begin
          if (stat.opcode == OP_DIV) begin
            if (stat.div_zero) begin
              cmd.action     = AC_FAULT;
              cmd.fault_code = ST_DIVZERO;
              state_nxt      = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end else begin
            cmd.action = AC_ALU;
            state_nxt  = S_DONE;
          end
        end else if (stat.opcode inside {[OP_LOAD:OP_CALL]}) begin
          cmd.addr_sel = AS_PC;
          cmd.mem_rd   = 1'b1;
          cmd.pc_inc   = 1'b1;
          state_nxt    = S_B1;
        end else if (stat.opcode == OP_RET) begin
          cmd.addr_sel = AS_SP;
          cmd.mem_rd   = 1'b1;
          cmd.sp_inc   = 1'b1;
          state_nxt    = S_POP1;
        end else begin
          cmd.action = AC_FAULT;
          if (stat.opcode == OP_HALT)         cmd.fault_code = ST_HALT;
          else if (stat.opcode == OP_SYSCALL) cmd.fault_code = ST_SYSCALL;
          else                                cmd.fault_code = ST_BADOP;
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.action = AC_ALU;
          state_nxt  = S_DONE;
        end
      end
      S_B1: begin
        // LOAD/STORE/MOVE take a register byte first, jumps a high byte.
        if (stat.opcode inside {OP_LOAD, OP_STORE, OP_MOVE})
          cmd.latch = LD_RA;
        else
          cmd.latch = LD_HI;
        cmd.addr_sel = AS_PC;
        cmd.mem_rd   = 1'b1;
        cmd.pc_inc   = 1'b1;
        state_nxt    = S_B2;
      end
      S_B2: begin
        if (stat.opcode == OP_MOVE) begin
          cmd.latch = LD_LO;
          state_nxt = S_B3;
        end else if (stat.opcode inside {OP_LOAD, OP_STORE}) begin
          cmd.latch    = LD_HI;
          cmd.addr_sel = AS_PC;
          cmd.mem_rd   = 1'b1;
          cmd.pc_inc   = 1'b1;
          state_nxt    = S_B3;
        end else begin
          cmd.latch = LD_LO;
          if (stat.opcode == OP_CALL) begin
            cmd.addr_sel  = AS_SP;
            cmd.sp_dec    = 1'b1;
            state_nxt     = S_PUSH2;
          end else begin
            state_nxt = S_MEMLD;
          end
        end
      end
      S_PUSH2: begin
        // SP already decremented once; write low byte, then high byte.
        cmd.addr_sel  = AS_SP;
        cmd.mem_wr    = 1'b1;
        cmd.wdata_sel = WD_PCLO;
        cmd.sp_dec    = 1'b1;
        state_nxt     = S_POP2;
      end
      S_POP2: begin
        if (stat.opcode == OP_CALL) begin
          cmd.addr_sel  = AS_SP;
          cmd.mem_wr    = 1'b1;
          cmd.wdata_sel = WD_PCHI;
          cmd.action    = AC_JUMP;
        end else begin
          cmd.action = AC_PCLOAD;
        end
        state_nxt = S_DONE;
      end
      S_POP1: begin
        cmd.latch    = LD_HI;
        cmd.addr_sel = AS_SP;
        cmd.mem_rd   = 1'b1;
        cmd.sp_inc   = 1'b1;
        state_nxt    = S_POP2;
      end
      S_MEMLD: begin
        if (stat.opcode == OP_JMP) cmd.action = AC_JUMP;
        else                       cmd.action = AC_JMPZ;
        state_nxt = S_DONE;
      end
      S_B3: begin
        if (stat.opcode == OP_MOVE) begin
          if (stat.ra_bad || stat.rb_bad) begin
            cmd.action     = AC_FAULT;
            cmd.fault_code = ST_BADREG;
          end else begin
            cmd.action = AC_MOVE;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.latch = LD_LO;
          state_nxt = S_MEMRD;
        end
      end
      S_MEMRD: begin
        if (stat.ra_bad) begin
          cmd.action     = AC_FAULT;
          cmd.fault_code = ST_BADREG;
          state_nxt      = S_DONE;
        end else if (stat.opcode == OP_STORE) begin
          cmd.addr_sel  = AS_TGT;
          cmd.mem_wr    = 1'b1;
          cmd.wdata_sel = WD_REG;
          state_nxt     = S_DONE;
        end else begin
          cmd.addr_sel = AS_TGT;
          cmd.mem_rd   = 1'b1;
          state_nxt    = S_HRD;
        end
      end
      S_HRD: begin
        cmd.latch = LD_REG;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free or being emptied.
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

/* src/toy_8bit_cpu_core_unit.sv */
// Top level of the toy 8-bit core: configuration registers, controller, datapath.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | t8c_in_t  (cmd, mem_addr, mem_data)
//  out_    | output    | out_valid / out_stall| t8c_out_t (status .. zero_flag)
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// One request in the core at a time: a step reads its opcode and operand bytes
// one at a time from the single-port byte memory, and a divide waits for the
// one-bit-a-cycle divider.
// Synchronous active-low reset clears registers, PC, SP, flags and control
// state; memory contents are undefined until written. A result waits in the
// output register while out_stall is high; the next request may run meanwhile
// and holds in its last cycle until the output register is free.
module toy_8bit_cpu_core_unit #(
  parameter int NUM_REGS  = 4,
  parameter int MEM_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  t8c_pkg::t8c_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output t8c_pkg::t8c_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);
  import t8c_pkg::*;

  localparam logic CFG_BOOT_PC   = 1'b0;
  localparam logic CFG_STACK_TOP = 1'b1;

  logic [15:0] boot_pc_r, stack_top_r;
  t8c_cmd_t    cmd;
  t8c_stat_t   stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_pc_r   <= '0;
      stack_top_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BOOT_PC)   boot_pc_r   <= cfg_data;
      if (cfg_index == CFG_STACK_TOP) stack_top_r <= cfg_data;
    end
  end

  t8c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_cmd   (in_data.cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  t8c_datapath #(
    .NUM_REGS  (NUM_REGS),
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (in_data),
    .boot_pc      (boot_pc_r),
    .stack_top    (stack_top_r),
    .cmd          (cmd),
    .stat         (stat),
    .res          (out_data)
  );

endmodule

/* sim/tb.sv */
// Testbench for toy_8bit_cpu_core_unit: directed and random host requests against a predictor.
`timescale 1ns / 1ps

module tb;
  import t8c_pkg::*;

  localparam int          NREGS            = 4;
  localparam int          WATCH_LIMIT      = 3000;
  localparam int          ITEMS_WANTED     = 1050;
  localparam logic        CFG_BOOT_PC      = 1'b0;
  localparam logic        CFG_STACK_TOP    = 1'b1;

  typedef enum logic [1:0] {ROLE_OPC, ROLE_REG, ROLE_ADDR, ROLE_DATA} byte_role_e;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  t8c_in_t   in_data;
  logic      out_valid;
  logic      out_stall;
  t8c_out_t  out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [15:0] cfg_data;

  toy_8bit_cpu_core_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predicted core state
  logic [7:0]  core_mem [0:65535];
  bit          mem_known [0:65535];
  logic [15:0] known_addrs [$];
  logic [7:0]  core_regs [0:NREGS-1];
  logic [15:0] core_pc, core_sp, vec_shadow, stack_shadow;
  logic        core_zf;
  logic [2:0]  core_stop;

  t8c_out_t    expected_results [$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic void mem_put(input logic [15:0] a, input logic [7:0] v);
    if (!mem_known[a]) known_addrs.push_back(a);
    mem_known[a] = 1'b1;
    core_mem[a] = v;
  endfunction

  function automatic logic [7:0] fetch();
    logic [7:0] v;
    v = core_mem[core_pc];
    core_pc = core_pc + 16'd1;
    return v;
  endfunction

  function automatic void run_instruction();
    logic [7:0]  op, ra, rb, hi, lo, res;
    logic [15:0] tgt;
    op = fetch();
    if (op <= OP_NOT) begin
      case (op)
        OP_ADD: res = core_regs[1] + core_regs[2];
        OP_SUB: res = core_regs[1] - core_regs[2];
        OP_MUL: res = core_regs[1] * core_regs[2];
        OP_DIV: begin
          if (core_regs[2] == 8'd0) begin
            core_stop = ST_DIVZERO;
            return;
          end
          res = core_regs[1] / core_regs[2];
        end
        OP_AND: res = core_regs[1] & core_regs[2];
        OP_OR:  res = core_regs[1] | core_regs[2];
        OP_XOR: res = core_regs[1] ^ core_regs[2];
        default: res = ~core_regs[1];
      endcase
      core_regs[0] = res;
      core_zf = (res == 8'd0);
      return;
    end
    case (op)
      OP_LOAD, OP_STORE: begin
        ra = fetch();
        hi = fetch();
        lo = fetch();
        if (ra >= NREGS) core_stop = ST_BADREG;
        else if (op == OP_LOAD) core_regs[ra] = core_mem[{hi, lo}];
        else mem_put({hi, lo}, core_regs[ra]);
      end
      OP_MOVE: begin
        ra = fetch();
        rb = fetch();
        if (ra >= NREGS || rb >= NREGS) core_stop = ST_BADREG;
        else core_regs[ra] = core_regs[rb];
      end
      OP_JMP, OP_JMPZ, OP_CALL: begin
        hi = fetch();
        lo = fetch();
        tgt = {hi, lo};
        if (op == OP_JMP || (op == OP_JMPZ && core_zf)) core_pc = tgt;
        if (op == OP_CALL) begin
          // push return address low byte first, pre-decrement
          core_sp = core_sp - 16'd1;
          mem_put(core_sp, core_pc[7:0]);
          core_sp = core_sp - 16'd1;
          mem_put(core_sp, core_pc[15:8]);
          core_pc = tgt;
        end
      end
      OP_RET: begin
        hi = core_mem[core_sp];
        core_sp = core_sp + 16'd1;
        lo = core_mem[core_sp];
        core_sp = core_sp + 16'd1;
        core_pc = {hi, lo};
      end
      OP_HALT:    core_stop = ST_HALT;
      OP_SYSCALL: core_stop = ST_SYSCALL;
      default:    core_stop = ST_BADOP;
    endcase
  endfunction

  function automatic t8c_out_t predict_result(input t8c_in_t x);
    t8c_out_t r;
    r.read_data = 8'd0;
    case (x.cmd)
      CMD_WRITE: mem_put(x.mem_addr, x.mem_data);
      CMD_READ:  r.read_data = core_mem[x.mem_addr];
      CMD_STEP:  if (core_stop == ST_OK) run_instruction();
      default: begin
        core_zf = 1'b0;
        core_sp = stack_shadow;
        core_pc = vec_shadow;
        core_stop = ST_OK;
      end
    endcase
    r.status = core_stop;
    r.prog_counter = core_pc;
    r.result_reg = core_regs[0];
    r.zero_flag = core_zf;
    return r;
  endfunction

  // First byte a step would read that was never written
  function automatic bit find_hole(output logic [15:0] a, output byte_role_e role);
    logic [7:0]  op;
    logic [15:0] p1, p2, p3;
    if (core_stop != ST_OK) return 1'b0;
    if (!mem_known[core_pc]) begin
      a = core_pc; role = ROLE_OPC; return 1'b1;
    end
    op = core_mem[core_pc];
    p1 = core_pc + 16'd1;
    p2 = core_pc + 16'd2;
    p3 = core_pc + 16'd3;
    case (op)
      OP_LOAD, OP_STORE, OP_MOVE: begin
        if (!mem_known[p1]) begin a = p1; role = ROLE_REG; return 1'b1; end
        if (!mem_known[p2]) begin
          a = p2; role = (op == OP_MOVE) ? ROLE_REG : ROLE_ADDR; return 1'b1;
        end
        if (op == OP_MOVE) return 1'b0;
        if (!mem_known[p3]) begin a = p3; role = ROLE_ADDR; return 1'b1; end
        if (op == OP_LOAD && core_mem[p1] < NREGS && !mem_known[{core_mem[p2], core_mem[p3]}])
        begin
          a = {core_mem[p2], core_mem[p3]}; role = ROLE_DATA; return 1'b1;
        end
      end
      OP_JMP, OP_JMPZ, OP_CALL: begin
        if (!mem_known[p1]) begin a = p1; role = ROLE_ADDR; return 1'b1; end
        if (!mem_known[p2]) begin a = p2; role = ROLE_ADDR; return 1'b1; end
      end
      OP_RET: begin
        if (!mem_known[core_sp]) begin a = core_sp; role = ROLE_ADDR; return 1'b1; end
        p1 = core_sp + 16'd1;
        if (!mem_known[p1]) begin a = p1; role = ROLE_ADDR; return 1'b1; end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [15:0] a, input logic [7:0] d);
    t8c_in_t x;
    int g;
    x.cmd = cmd;
    x.mem_addr = a;
    x.mem_data = d;
    in_data  <= x;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_result(x));
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic put_byte(input logic [15:0] a, input logic [7:0] d);
    send(CMD_WRITE, a, d);
  endtask

  // Step once, first filling any unwritten byte it would read
  task automatic step_filled();
    logic [15:0] a;
    byte_role_e  role;
    logic [7:0]  v;
    int r;
    while (find_hole(a, role)) begin
      r = $urandom_range(0, 99);
      case (role)
        ROLE_OPC:
          if (r < 85) v = 8'($urandom_range(0, 14));
          else if (r < 92) v = OP_HALT;
          else if (r < 96) v = OP_SYSCALL;
          else v = 8'($urandom_range(0, 255));
        ROLE_REG: v = (r < 92) ? 8'($urandom_range(0, NREGS - 1)) : 8'($urandom_range(0, 255));
        default:  v = 8'($urandom_range(0, 255));
      endcase
      put_byte(a, v);
    end
    send(CMD_STEP, 16'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BOOT_PC) vec_shadow = v;
    else stack_shadow = v;
  endtask

  task automatic test_host_access();
    put_byte(16'h0000, 8'h00);
    put_byte(16'hFFFF, 8'hFF);
    put_byte(16'h5AA5, 8'hA5);
    send(CMD_READ, 16'hFFFF, 8'h00);
    send(CMD_READ, 16'h0000, 8'hFF);
    send(CMD_READ, 16'h5AA5, 8'h00);
  endtask

  task automatic test_faults_and_calls();
    drain();
    write_reg(CFG_BOOT_PC, 16'h0100);
    write_reg(CFG_STACK_TOP, 16'h0000);
    // divide by zero, then a step while stopped
    put_byte(16'h0100, OP_DIV);
    send(CMD_RESTART, 16'h0, 8'h0);
    send(CMD_STEP, 16'h0, 8'h0);
    send(CMD_STEP, 16'h0, 8'h0);
    // call through the wrapped stack, return, halt
    put_byte(16'h0100, OP_CALL);
    put_byte(16'h0101, 8'hFF);
    put_byte(16'h0102, 8'hF0);
    put_byte(16'hFFF0, OP_RET);
    put_byte(16'h0103, OP_HALT);
    send(CMD_RESTART, 16'h0, 8'h0);
    repeat (3) send(CMD_STEP, 16'h0, 8'h0);
    put_byte(16'h0100, OP_SYSCALL);
    send(CMD_RESTART, 16'h0, 8'h0);
    send(CMD_STEP, 16'h0, 8'h0);
    put_byte(16'h0100, 8'hFF);
    send(CMD_RESTART, 16'h0, 8'h0);
    send(CMD_STEP, 16'h0, 8'h0);
    // bad register operand on a move
    put_byte(16'h0100, OP_MOVE);
    send(CMD_RESTART, 16'h0, 8'h0);
    send(CMD_STEP, 16'h0, 8'h0);
  endtask

  task automatic test_random_programs();
    int phase, r, n;
    logic [15:0] a;
    phase = 0;
    while (items_sent < ITEMS_WANTED) begin
      drain();
      quiet = (phase % 4 == 3);
      case (phase % 5)
        0: begin
          write_reg(CFG_BOOT_PC, 16'hFFFF);
          write_reg(CFG_STACK_TOP, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_BOOT_PC, 16'h0000);
          write_reg(CFG_STACK_TOP, 16'h0000);
        end
        default: begin
          write_reg(CFG_BOOT_PC, 16'($urandom));
          write_reg(CFG_STACK_TOP, 16'($urandom));
        end
      endcase
      send(CMD_RESTART, 16'($urandom), 8'($urandom));
      for (n = 0; n < 100 && items_sent < ITEMS_WANTED; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // mostly keep the program running
          if (core_stop != ST_OK && $urandom_range(0, 3) != 0)
            send(CMD_RESTART, 16'($urandom), 8'($urandom));
          else
            step_filled();
        end else if (r < 82) begin
          send(CMD_WRITE, 16'($urandom), 8'($urandom));
        end else if (r < 94) begin
          a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
          send(CMD_READ, a, 8'($urandom));
        end else begin
          send(CMD_RESTART, 16'($urandom), 8'($urandom));
        end
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  // Result stall: alternate runs of stalling and accepting
  int stall_hold = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_hold = gap_len();
      out_stall <= (stall_hold > 0) ? ~out_stall : 1'b0;
    end
  end

  always @(posedge clk) begin
    t8c_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 32'(out_data.prog_counter), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report("status", 32'(out_data.status), 32'(want.status));
        if (out_data.read_data !== want.read_data)
          report("read_data", 32'(out_data.read_data), 32'(want.read_data));
        if (out_data.prog_counter !== want.prog_counter)
          report("prog_counter", 32'(out_data.prog_counter), 32'(want.prog_counter));
        if (out_data.result_reg !== want.result_reg)
          report("result_reg", 32'(out_data.result_reg), 32'(want.result_reg));
        if (out_data.zero_flag !== want.zero_flag)
          report("zero_flag", 32'(out_data.zero_flag), 32'(want.zero_flag));
      end
    end
  end

  // Watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data  <= 16'd0;
    vec_shadow = 16'd0;
    stack_shadow = 16'd0;
    core_pc = 16'd0;
    core_sp = 16'd0;
    core_zf = 1'b0;
    core_stop = ST_OK;
    for (int i = 0; i < NREGS; i++) core_regs[i] = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_host_access();
    test_faults_and_calls();
    test_random_programs();
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* toy_8bit_cpu_core_unit.f */
src/t8c_pkg.sv
src/t8c_datapath.sv
src/t8c_ctrl.sv
src/toy_8bit_cpu_core_unit.sv
sim/tb.sv
